// ===== rtl/brm_pkg.sv =====
// ----------------------------------------------------------------------------
// brm_pkg
// Shared widths, register map and types of the breath rate monitor.
// ----------------------------------------------------------------------------
package brm_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int THR_BITS    = 12;
   localparam int MS_BITS     = 16;
   localparam int TIME_BITS   = 32;
   localparam int COUNT_BITS  = 8;
   localparam int LEVEL_BITS  = 2;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 32;
   // signed compare width for the release level against a sample
   localparam int CMP_BITS    = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      REG_PEAK_THRESHOLD  = 3'd0,
      REG_RELEASE_HYST    = 3'd1,
      REG_REFRACTORY_MS   = 3'd2,
      REG_WINDOW_MS       = 3'd3,
      REG_GUIDE_HALF_MS   = 3'd4,
      REG_REPORT_INTERVAL = 3'd5
   } brm_reg_type;

   typedef enum logic [LEVEL_BITS-1:0] {
      LEVEL_NONE   = 2'd0,
      LEVEL_GREEN  = 2'd1,
      LEVEL_YELLOW = 2'd2,
      LEVEL_RED    = 2'd3
   } brm_level_type;

   typedef struct packed {
      logic [THR_BITS-1:0] peak_threshold;
      logic [THR_BITS-1:0] release_hysteresis;
      logic [MS_BITS-1:0]  refractory_ms;
      logic [MS_BITS-1:0]  window_ms;
      logic [MS_BITS-1:0]  guide_half_period_ms;
      logic [MS_BITS-1:0]  report_interval_ms;
   } brm_cfg_type;

endpackage

// ===== rtl/brm_req_if.sv =====
// ----------------------------------------------------------------------------
// brm_req_if
// Sample channel: one sensor sample and its millisecond timestamp per item.
// ----------------------------------------------------------------------------
interface brm_req_if import brm_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic [TIME_BITS-1:0]   now_ms;

   modport source (output valid, output sample, output now_ms, input ready);
   modport sink   (input valid, input sample, input now_ms, output ready);

endinterface

// ===== rtl/brm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// brm_rsp_if
// Result channel: detection, window, guide and report flags per item.
// ----------------------------------------------------------------------------
interface brm_rsp_if import brm_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic                   breath_detected;
   logic                   window_done;
   logic [LEVEL_BITS-1:0]  rate_level;
   logic [COUNT_BITS-1:0]  running_count;
   logic                   inhale_led;
   logic                   report_due;
   logic [COUNT_BITS-1:0]  report_count;
   logic [SAMPLE_BITS-1:0] report_sample;

   modport source (output valid, output breath_detected, output window_done,
                   output rate_level, output running_count, output inhale_led,
                   output report_due, output report_count, output report_sample,
                   input ready);
   modport sink   (input valid, input breath_detected, input window_done,
                   input rate_level, input running_count, input inhale_led,
                   input report_due, input report_count, input report_sample,
                   output ready);

endinterface

// ===== rtl/brm_csr.sv =====
// ----------------------------------------------------------------------------
// brm_csr
// APB-style register file holding thresholds and timing intervals.
// ----------------------------------------------------------------------------
module brm_csr import brm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output brm_cfg_type          cfg
);

   brm_cfg_type cfg_ff;
   brm_cfg_type cfg_in;
   brm_reg_type reg_sel;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_sel = brm_reg_type'(paddr[ADDR_BITS-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_PEAK_THRESHOLD:  cfg_in.peak_threshold       = pwdata[THR_BITS-1:0];
            REG_RELEASE_HYST:    cfg_in.release_hysteresis   = pwdata[THR_BITS-1:0];
            REG_REFRACTORY_MS:   cfg_in.refractory_ms        = pwdata[MS_BITS-1:0];
            REG_WINDOW_MS:       cfg_in.window_ms            = pwdata[MS_BITS-1:0];
            REG_GUIDE_HALF_MS:   cfg_in.guide_half_period_ms = pwdata[MS_BITS-1:0];
            REG_REPORT_INTERVAL: cfg_in.report_interval_ms   = pwdata[MS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PEAK_THRESHOLD:  prdata = DATA_BITS'(cfg_ff.peak_threshold);
         REG_RELEASE_HYST:    prdata = DATA_BITS'(cfg_ff.release_hysteresis);
         REG_REFRACTORY_MS:   prdata = DATA_BITS'(cfg_ff.refractory_ms);
         REG_WINDOW_MS:       prdata = DATA_BITS'(cfg_ff.window_ms);
         REG_GUIDE_HALF_MS:   prdata = DATA_BITS'(cfg_ff.guide_half_period_ms);
         REG_REPORT_INTERVAL: prdata = DATA_BITS'(cfg_ff.report_interval_ms);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_threshold       <= THR_BITS'(1000);
         cfg_ff.release_hysteresis   <= THR_BITS'(200);
         cfg_ff.refractory_ms        <= MS_BITS'(1000);
         cfg_ff.window_ms            <= MS_BITS'(4000);
         cfg_ff.guide_half_period_ms <= MS_BITS'(4000);
         cfg_ff.report_interval_ms   <= MS_BITS'(200);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/brm_core.sv =====
// ----------------------------------------------------------------------------
// brm_core
// Input register, breath/window/guide/report state and result register.
// ----------------------------------------------------------------------------
module brm_core import brm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  brm_cfg_type cfg,
   brm_req_if.sink     req_ch,
   brm_rsp_if.source   rsp_ch
);

   // input stage
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic [TIME_BITS-1:0]   in_now_ff;

   // monitor state
   logic                   in_breath_ff,   in_breath_in;
   logic [COUNT_BITS-1:0]  count_ff,       count_in;
   logic [TIME_BITS-1:0]   last_breath_ff, last_breath_in;
   logic [TIME_BITS-1:0]   window_start_ff, window_start_in;
   logic [TIME_BITS-1:0]   guide_start_ff, guide_start_in;
   logic                   inhaling_ff,    inhaling_in;
   logic [TIME_BITS-1:0]   last_report_ff, last_report_in;
   logic [LEVEL_BITS-1:0]  level_ff,       level_in;

   // result stage
   logic                   out_valid_ff;
   logic                   out_detected_ff, out_done_ff, out_led_ff, out_due_ff;
   logic [LEVEL_BITS-1:0]  out_level_ff;
   logic [COUNT_BITS-1:0]  out_count_ff, out_rep_count_ff;
   logic [SAMPLE_BITS-1:0] out_rep_sample_ff;

   logic                   advance;
   logic                   take;
   logic [TIME_BITS-1:0]   el_report, el_breath, el_window, el_guide;
   logic                   due, detect, release_hit, done, toggle;
   logic [COUNT_BITS-1:0]  count_mid;
   logic signed [CMP_BITS-1:0] release_level;
   logic signed [CMP_BITS-1:0] sample_s;

   assign advance = in_valid_ff & (~out_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~in_valid_ff | advance;
   assign take = req_ch.valid & req_ch.ready;

   // wrapping elapsed times
   assign el_report = in_now_ff - last_report_ff;
   assign el_breath = in_now_ff - last_breath_ff;
   assign el_window = in_now_ff - window_start_ff;
   assign el_guide  = in_now_ff - guide_start_ff;

   assign due    = el_report >= TIME_BITS'(cfg.report_interval_ms);
   assign done   = el_window >= TIME_BITS'(cfg.window_ms);
   assign toggle = el_guide  >= TIME_BITS'(cfg.guide_half_period_ms);

   assign release_level = signed'(CMP_BITS'(cfg.peak_threshold))
                        - signed'(CMP_BITS'(cfg.release_hysteresis));
   assign sample_s      = signed'(CMP_BITS'(in_sample_ff));

   assign detect = (CMP_BITS'(in_sample_ff) > CMP_BITS'(cfg.peak_threshold)) & ~in_breath_ff
                 & (el_breath > TIME_BITS'(cfg.refractory_ms));
   assign release_hit = ~detect & in_breath_ff & (sample_s <= release_level);

   always_comb begin
      count_mid = count_ff;
      if (detect && count_ff != COUNT_MAX) begin
         count_mid = count_ff + COUNT_BITS'(1);
      end

      in_breath_in   = detect ? 1'b1 : (release_hit ? 1'b0 : in_breath_ff);
      last_breath_in = detect ? in_now_ff : last_breath_ff;
      last_report_in = due ? in_now_ff : last_report_ff;

      level_in        = level_ff;
      count_in        = count_mid;
      window_start_in = window_start_ff;
      if (done) begin
         if (count_mid <= COUNT_BITS'(1)) begin
            level_in = LEVEL_GREEN;
         end else if (count_mid == COUNT_BITS'(2)) begin
            level_in = LEVEL_YELLOW;
         end else begin
            level_in = LEVEL_RED;
         end
         count_in        = '0;
         window_start_in = in_now_ff;
      end

      inhaling_in    = toggle ? ~inhaling_ff : inhaling_ff;
      guide_start_in = toggle ? in_now_ff : guide_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         in_breath_ff    <= 1'b0;
         count_ff        <= '0;
         last_breath_ff  <= '0;
         window_start_ff <= '0;
         guide_start_ff  <= '0;
         inhaling_ff     <= 1'b1;
         last_report_ff  <= '0;
         level_ff        <= LEVEL_NONE;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            in_breath_ff    <= in_breath_in;
            count_ff        <= count_in;
            last_breath_ff  <= last_breath_in;
            window_start_ff <= window_start_in;
            guide_start_ff  <= guide_start_in;
            inhaling_ff     <= inhaling_in;
            last_report_ff  <= last_report_in;
            level_ff        <= level_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_sample_ff <= req_ch.sample;
         in_now_ff    <= req_ch.now_ms;
      end
      if (advance) begin
         out_detected_ff   <= detect;
         out_done_ff       <= done;
         out_level_ff      <= level_in;
         out_count_ff      <= count_in;
         out_led_ff        <= inhaling_ff;
         out_due_ff        <= due;
         out_rep_count_ff  <= due ? count_ff : '0;
         out_rep_sample_ff <= due ? in_sample_ff : '0;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.breath_detected = out_detected_ff;
   assign rsp_ch.window_done     = out_done_ff;
   assign rsp_ch.rate_level      = out_level_ff;
   assign rsp_ch.running_count   = out_count_ff;
   assign rsp_ch.inhale_led      = out_led_ff;
   assign rsp_ch.report_due      = out_due_ff;
   assign rsp_ch.report_count    = out_rep_count_ff;
   assign rsp_ch.report_sample   = out_rep_sample_ff;

endmodule

// ===== rtl/breath_rate_monitor_top.sv =====
// an accepted sample passes the input register and then the result register
// throughput: one sample per cycle while the result side is not stalled; the state update sits in the single step
// between the input register and the result register
// reset: synchronous, active high; registers return to their defaults, state
// clears, guide starts on inhale, both pipeline stages empty
// ----------------------------------------------------------------------------
// breath_rate_monitor_top
// Breath counter with hysteresis, refractory time, rate window, guide and report.
// ----------------------------------------------------------------------------
module breath_rate_monitor_top import brm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   brm_req_if.sink              req_ch,
   brm_rsp_if.source            rsp_ch,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   brm_cfg_type cfg;

   brm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   brm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== verif/breath_rate_monitor_top_tb.sv =====
// ----------------------------------------------------------------------------
// breath_rate_monitor_top_tb
// Streams timestamped sensor samples through the breath rate monitor under
// several register settings. Each accepted sample is run through a local
// model of the breath, window, guide and report logic. Every result item is
// checked field by field against the oldest prediction. Register writes are
// read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module breath_rate_monitor_top_tb import brm_pkg::*; ();

   localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;

   // addresses past the register list, writes there are dropped
   localparam logic [2:0] SPARE_REG_LO = 3'd6;
   localparam logic [2:0] SPARE_REG_HI = 3'd7;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [TIME_BITS-1:0]   now_ms;
   } sample_item_type;

   typedef struct packed {
      logic                   breath_detected;
      logic                   window_done;
      brm_level_type          rate_level;
      logic [COUNT_BITS-1:0]  running_count;
      logic                   inhale_led;
      logic                   report_due;
      logic [COUNT_BITS-1:0]  report_count;
      logic [SAMPLE_BITS-1:0] report_sample;
   } breath_result_type;

   logic                 clock;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   brm_req_if req_bus ();
   brm_rsp_if rsp_bus ();

   breath_rate_monitor_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // register copy and breath state of the local model
   brm_cfg_type cfg_model = '{
      peak_threshold:       12'd1000,
      release_hysteresis:   12'd200,
      refractory_ms:        16'd1000,
      window_ms:            16'd4000,
      guide_half_period_ms: 16'd4000,
      report_interval_ms:   16'd200
   };
   logic                  in_breath        = 1'b0;
   logic [COUNT_BITS-1:0] breath_count     = '0;
   logic [TIME_BITS-1:0]  last_breath_ms   = '0;
   logic [TIME_BITS-1:0]  window_start_ms  = '0;
   logic [TIME_BITS-1:0]  guide_start_ms   = '0;
   logic                  inhaling         = 1'b1;
   logic [TIME_BITS-1:0]  last_report_ms   = '0;
   brm_level_type         level_latch      = LEVEL_NONE;

   sample_item_type   pending_samples[$];
   breath_result_type predicted_results[$];

   logic [TIME_BITS-1:0] stamp_ms = '0;
   bit  gaps_on     = 1'b1;
   bit  req_taken;
   int  hold_asked  = 0;
   int  hold_seen   = 0;
   int  hold_left   = 0;
   int  cycle_count = 0;
   int  mismatches  = 0;
   int  n_results   = 0;
   int  n_breaths   = 0;
   int  n_windows   = 0;
   int  n_reports   = 0;
   int  n_settings  = 1;
   int  top_count   = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [TIME_BITS-1:0] ms_since(logic [TIME_BITS-1:0] now,
                                                     logic [TIME_BITS-1:0] then);
      return now - then;
   endfunction

   function automatic breath_result_type predict_breath(logic [SAMPLE_BITS-1:0] s,
                                                        logic [TIME_BITS-1:0]   now);
      breath_result_type r;
      int release_level;
      r = '0;
      release_level = int'(cfg_model.peak_threshold) - int'(cfg_model.release_hysteresis);

      // report sees the count from before this item
      if (ms_since(now, last_report_ms) >= 32'(cfg_model.report_interval_ms)) begin
         r.report_due    = 1'b1;
         r.report_count  = breath_count;
         r.report_sample = s;
         last_report_ms  = now;
      end

      if (s > cfg_model.peak_threshold && !in_breath &&
          ms_since(now, last_breath_ms) > 32'(cfg_model.refractory_ms)) begin
         if (breath_count != COUNT_MAX) begin
            breath_count++;
         end
         in_breath         = 1'b1;
         last_breath_ms    = now;
         r.breath_detected = 1'b1;
      end else if (in_breath && int'(s) <= release_level) begin
         in_breath = 1'b0;
      end

      if (ms_since(now, window_start_ms) >= 32'(cfg_model.window_ms)) begin
         if (breath_count <= 1) begin
            level_latch = LEVEL_GREEN;
         end else if (breath_count == 2) begin
            level_latch = LEVEL_YELLOW;
         end else begin
            level_latch = LEVEL_RED;
         end
         breath_count    = '0;
         window_start_ms = now;
         r.window_done   = 1'b1;
      end

      // led shows the phase before any toggle
      r.inhale_led = inhaling;
      if (ms_since(now, guide_start_ms) >= 32'(cfg_model.guide_half_period_ms)) begin
         inhaling       = !inhaling;
         guide_start_ms = now;
      end

      r.rate_level    = level_latch;
      r.running_count = breath_count;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void store_register(logic [2:0] idx, logic [DATA_BITS-1:0] value);
      case (idx)
         REG_PEAK_THRESHOLD:  cfg_model.peak_threshold       = value[THR_BITS-1:0];
         REG_RELEASE_HYST:    cfg_model.release_hysteresis   = value[THR_BITS-1:0];
         REG_REFRACTORY_MS:   cfg_model.refractory_ms        = value[MS_BITS-1:0];
         REG_WINDOW_MS:       cfg_model.window_ms            = value[MS_BITS-1:0];
         REG_GUIDE_HALF_MS:   cfg_model.guide_half_period_ms = value[MS_BITS-1:0];
         REG_REPORT_INTERVAL: cfg_model.report_interval_ms   = value[MS_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [DATA_BITS-1:0] register_value(logic [2:0] idx);
      case (idx)
         REG_PEAK_THRESHOLD:  return DATA_BITS'(cfg_model.peak_threshold);
         REG_RELEASE_HYST:    return DATA_BITS'(cfg_model.release_hysteresis);
         REG_REFRACTORY_MS:   return DATA_BITS'(cfg_model.refractory_ms);
         REG_WINDOW_MS:       return DATA_BITS'(cfg_model.window_ms);
         REG_GUIDE_HALF_MS:   return DATA_BITS'(cfg_model.guide_half_period_ms);
         default:             return DATA_BITS'(cfg_model.report_interval_ms);
      endcase
   endfunction

   // well-formed samples land above the threshold or at/below the release level,
   // now and then right on the boundary
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(bit high);
      int thr;
      int rel;
      thr = cfg_model.peak_threshold;
      rel = thr - int'(cfg_model.release_hysteresis);
      if (high && thr < SAMPLE_MAX) begin
         if ($urandom_range(4, 0) == 0) begin
            return SAMPLE_BITS'($urandom_range(1, 0) ? thr + 1 : thr);
         end
         return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, thr + 1));
      end
      if (!high && rel >= 0) begin
         if ($urandom_range(4, 0) == 0) begin
            return SAMPLE_BITS'((rel < SAMPLE_MAX && $urandom_range(1, 0)) ? rel + 1 : rel);
         end
         return SAMPLE_BITS'($urandom_range(rel, 0));
      end
      return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0));
   endfunction

   task automatic push_sample(int s, logic [TIME_BITS-1:0] t);
      pending_samples.push_back('{sample: SAMPLE_BITS'(s), now_ms: t});
   endtask

   // breath-shaped runs of high and low samples, with some noise and time jumps
   task automatic feed_breaths(int count, int step_min, int step_max, int run_max,
                               int noise_pct);
      bit high;
      int run;
      high = 1'b0;
      run  = 0;
      for (int i = 0; i < count; i++) begin
         if (run == 0) begin
            high = !high;
            run  = $urandom_range(run_max, 1);
         end
         run--;
         if ($urandom_range(99, 0) < noise_pct) begin
            if ($urandom_range(9, 0) == 0) begin
               stamp_ms = $urandom();
            end else begin
               stamp_ms += $urandom_range(step_max, step_min);
            end
            push_sample($urandom_range(SAMPLE_MAX, 0), stamp_ms);
         end else begin
            stamp_ms += $urandom_range(step_max, step_min);
            push_sample(pick_sample(high), stamp_ms);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_bus.valid || predicted_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [DATA_BITS-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      store_register(idx, value);
      // read straight back
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx <= REG_REPORT_INTERVAL) begin
         check_field($sformatf("readback of register %0d", idx), register_value(idx), prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_registers(int thr, int hyst, int refr, int window, int guide,
                                int report);
      csr_write(REG_PEAK_THRESHOLD, DATA_BITS'(thr));
      csr_write(REG_RELEASE_HYST, DATA_BITS'(hyst));
      csr_write(REG_REFRACTORY_MS, DATA_BITS'(refr));
      csr_write(REG_WINDOW_MS, DATA_BITS'(window));
      csr_write(REG_GUIDE_HALF_MS, DATA_BITS'(guide));
      csr_write(REG_REPORT_INTERVAL, DATA_BITS'(report));
      n_settings++;
   endtask

   // sample driver
   always @(negedge clock) begin : drive_samples
      sample_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_samples.size() != 0 && !(gaps_on && $urandom_range(99, 0) < 33)) begin
            next_item = pending_samples.pop_front();
            req_bus.valid  <= 1'b1;
            req_bus.sample <= next_item.sample;
            req_bus.now_ms <= next_item.now_ms;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver, with random stalls and the occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen     <= hold_asked;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !(gaps_on && $urandom_range(99, 0) < 33);
      end
   end

   // monitor: predict on accepted samples, check accepted results
   always @(posedge clock) begin : watch_results
      breath_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_results.size() == 0) begin
               $error("result item arrived with no sample outstanding");
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               check_field("breath_detected", want.breath_detected, rsp_bus.breath_detected);
               check_field("window_done", want.window_done, rsp_bus.window_done);
               check_field("rate_level", want.rate_level, rsp_bus.rate_level);
               check_field("running_count", want.running_count, rsp_bus.running_count);
               check_field("inhale_led", want.inhale_led, rsp_bus.inhale_led);
               check_field("report_due", want.report_due, rsp_bus.report_due);
               check_field("report_count", want.report_count, rsp_bus.report_count);
               check_field("report_sample", want.report_sample, rsp_bus.report_sample);
               n_results++;
               n_breaths += want.breath_detected;
               n_windows += want.window_done;
               n_reports += want.report_due;
               if (want.running_count > top_count) begin
                  top_count = want.running_count;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted_results.push_back(predict_breath(req_bus.sample, req_bus.now_ms));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      req_bus.now_ms = '0;
      rsp_bus.ready  = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: refractory and release boundaries, window close,
      // guide toggle, then the top of the timestamp range
      push_sample(0, 0);
      push_sample(SAMPLE_MAX, 1000);
      push_sample(SAMPLE_MAX, 1001);
      push_sample(1001, 1100);
      push_sample(800, 1200);
      push_sample(1001, 2001);
      push_sample(1001, 2002);
      push_sample(0, 2100);
      push_sample(2000, 3100);
      push_sample(0, 3200);
      push_sample(0, 4000);
      push_sample(0, 4001);
      push_sample(SAMPLE_MAX, 32'hFFFF_FFFF);
      push_sample(0, 32'h0000_0000);
      stamp_ms = '0;
      feed_breaths(250, 0, 200, 3, 10);
      wait_drained();

      // busy settings, with a long hold-off on the result side
      set_registers(2000, 500, 30, 200, 50, 25);
      feed_breaths(300, 0, 15, 4, 10);
      @(posedge clock);
      hold_asked++;
      wait_drained();

      // back-to-back breaths until the count saturates
      set_registers(2000, 100, 0, 65535, 65535, 65535);
      feed_breaths(540, 1, 1, 1, 0);
      wait_drained();

      // extremes with masked writes, spare addresses and timestamps wrapping;
      // hysteresis above threshold keeps the breath from ending
      csr_write(REG_PEAK_THRESHOLD, 32'hFFFF_F000);
      csr_write(REG_RELEASE_HYST, 32'h0000_0FFF);
      csr_write(REG_REFRACTORY_MS, 32'h7FFF_FFFF);
      csr_write(REG_WINDOW_MS, 32'h0001_0001);
      csr_write(REG_GUIDE_HALF_MS, 32'hABCD_0001);
      csr_write(REG_REPORT_INTERVAL, 32'hFFFE_0001);
      csr_write(SPARE_REG_LO, $urandom());
      csr_write(SPARE_REG_HI, $urandom());
      n_settings++;
      stamp_ms = 32'hFFFF_FF80;
      feed_breaths(150, 0, 3, 3, 20);
      wait_drained();

      // zero window, guide and report: window, guide and report all fire on each item
      set_registers(SAMPLE_MAX, 0, 0, 0, 0, 0);
      feed_breaths(100, 0, 5000, 2, 50);
      wait_drained();

      // no idling on either side
      gaps_on = 1'b0;
      set_registers(1500, 0, 5, 40, 9, 3);
      feed_breaths(300, 0, 4, 4, 5);
      wait_drained();
      gaps_on = 1'b1;

      // random settings, sender pauses halfway until all results are in
      set_registers($urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0),
                    $urandom_range(50, 0), $urandom_range(300, 1),
                    $urandom_range(100, 1), $urandom_range(60, 1));
      feed_breaths(150, 0, 10, 4, 15);
      wait_drained();
      feed_breaths(150, 0, 10, 4, 15);
      wait_drained();

      $display("checked %0d result items over %0d register settings", n_results, n_settings);
      $display("%0d breaths counted, %0d windows closed, %0d reports, top count %0d",
               n_breaths, n_windows, n_reports, top_count);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/brm_pkg.sv
rtl/brm_req_if.sv
rtl/brm_rsp_if.sv
rtl/brm_csr.sv
rtl/brm_core.sv
rtl/breath_rate_monitor_top.sv
verif/breath_rate_monitor_top_tb.sv
